>>> design/pid_controller_three_mode_core_assert.svh
// assertion macros shared by the pid controller modules
`ifndef PID_CONTROLLER_THREE_MODE_CORE_ASSERT_SVH
`define PID_CONTROLLER_THREE_MODE_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define PIDTM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define PIDTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pidtm_pkg.sv
// types, constants and saturation helpers of the pid controller
package pidtm_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_W      = DATA_WIDTH + 4;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int CFG_IDX_W  = 3;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [ACC_W-1:0]      acc_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  localparam data_t BAND_WIDE     = data_t'(50 * (2 ** FRAC_BITS));
  localparam data_t NEG_BAND_WIDE = -BAND_WIDE;
  localparam data_t WINDOW        = data_t'(200 * (2 ** FRAC_BITS));
  localparam data_t NEG_WINDOW    = -WINDOW;
  localparam data_t BAND_FINE     = data_t'(((2 ** FRAC_BITS) + 2) / 5);
  localparam data_t NEG_BAND_FINE = -BAND_FINE;

  typedef enum logic [1:0] {
    MODE_POS  = 2'd0,
    MODE_BAND = 2'd1,
    MODE_INCR = 2'd2
  } law_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_SETPOINT     = 3'd3,
    REG_LAW_MODE     = 3'd4,
    REG_INTEGRAL_MAX = 3'd5,
    REG_INTEGRAL_MIN = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    data_t val;
    logic  ovf;
  } sat_t;

  // multiplicands for the three gains plus the item's flags
  typedef struct packed {
    data_t x_p;
    data_t x_i;
    data_t x_d;
    logic  ovf;
    logic  incr;
  } opnd_t;

  function automatic acc_t to_acc(input data_t x);
    return acc_t'(x);
  endfunction

  function automatic sat_t sat_acc(input acc_t x);
    sat_t r;
    logic fits;
    fits  = (&x[ACC_W-1:DATA_WIDTH-1]) | ~(|x[ACC_W-1:DATA_WIDTH-1]);
    r.ovf = ~fits;
    if (fits) begin
      r.val = x[DATA_WIDTH-1:0];
    end else if (x[ACC_W-1]) begin
      r.val = DATA_MIN;
    end else begin
      r.val = DATA_MAX;
    end
    return r;
  endfunction

endpackage

>>> design/pidtm_mulq.sv
// registered fixed-point multiply: floor shift by the fraction bits, then saturate
module pidtm_mulq import pidtm_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  data_t gain_i,
  input  data_t x_i,
  output data_t prod_o,
  output logic  ovf_o
);

  logic signed [PROD_W-1:0] full;
  logic signed [PROD_W-1:0] shifted;
  logic                     fits;
  data_t                    prod_d;
  data_t                    prod_q;
  logic                     ovf_q;

  always_comb begin
    full    = gain_i * x_i;
    shifted = full >>> FRAC_BITS;
    fits    = (&shifted[PROD_W-1:DATA_WIDTH-1]) | ~(|shifted[PROD_W-1:DATA_WIDTH-1]);
    if (fits) begin
      prod_d = shifted[DATA_WIDTH-1:0];
    end else if (full[PROD_W-1]) begin
      prod_d = DATA_MIN;
    end else begin
      prod_d = DATA_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      ovf_q  <= ~fits;
    end
  end

  assign prod_o = prod_q;
  assign ovf_o  = ovf_q;

endmodule

>>> design/pidtm_front.sv
// error, dead band and integral stage with the controller's error history
`include "pid_controller_three_mode_core_assert.svh"

module pidtm_front import pidtm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  data_t     measured_i,
  input  data_t     setpoint_i,
  input  law_mode_e law_mode_i,
  input  data_t     integral_max_i,
  input  data_t     integral_min_i,
  output opnd_t     opnd_o
);

  data_t integral_q, integral_d;
  data_t error_prev_q, error_prev2_q;
  data_t e_new;

  sat_t  err;
  sat_t  diff1;
  sat_t  diff2;
  sat_t  int_pos;
  data_t e_fine;
  data_t e_band;
  data_t int_base;
  data_t int_band;
  acc_t  int_sum;
  logic  in_band;
  logic  in_window;

  always_comb begin
    err = sat_acc(to_acc(setpoint_i) - to_acc(measured_i));

    // incremental law: small errors count as zero
    e_fine = (err.val < BAND_FINE && err.val > NEG_BAND_FINE) ? '0 : err.val;

    // dead band law: a small error also empties the integral
    in_band   = (err.val >= NEG_BAND_WIDE) && (err.val <= BAND_WIDE);
    e_band    = in_band ? '0 : err.val;
    int_base  = in_band ? '0 : integral_q;
    in_window = (e_band > NEG_WINDOW) && (e_band < WINDOW);
    int_sum   = to_acc(int_base) + to_acc(e_band);
    // upper limit is tested first, so with crossed limits a sum above it gives the upper one, any other the lower
    if (!in_window) begin
      int_band = int_base;
    end else if (int_sum > to_acc(integral_max_i)) begin
      int_band = integral_max_i;
    end else if (int_sum < to_acc(integral_min_i)) begin
      int_band = integral_min_i;
    end else begin
      int_band = int_sum[DATA_WIDTH-1:0];
    end

    int_pos = sat_acc(to_acc(integral_q) + to_acc(err.val));

    unique case (law_mode_i)
      MODE_INCR: begin
        e_new      = e_fine;
        integral_d = integral_q;
      end
      MODE_BAND: begin
        e_new      = e_band;
        integral_d = int_band;
      end
      default: begin
        e_new      = err.val;
        integral_d = int_pos.val;
      end
    endcase

    diff1 = sat_acc(to_acc(e_new) - to_acc(error_prev_q));
    diff2 = sat_acc(to_acc(e_new) - (to_acc(error_prev_q) <<< 1) + to_acc(error_prev2_q));

    if (law_mode_i == MODE_INCR) begin
      opnd_o.x_p  = diff1.val;
      opnd_o.x_i  = e_new;
      opnd_o.x_d  = diff2.val;
      opnd_o.ovf  = err.ovf | diff1.ovf | diff2.ovf;
      opnd_o.incr = 1'b1;
    end else begin
      opnd_o.x_p  = e_new;
      opnd_o.x_i  = integral_d;
      opnd_o.x_d  = diff1.val;
      opnd_o.ovf  = err.ovf | diff1.ovf;
      opnd_o.incr = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q    <= '0;
      error_prev_q  <= '0;
      error_prev2_q <= '0;
    end else if (step_i) begin
      integral_q    <= integral_d;
      error_prev_q  <= e_new;
      error_prev2_q <= error_prev_q;
    end
  end

  `PIDTM_ASSERT_NEXT(a_state_hold, !step_i,
    $stable(error_prev_q) && $stable(integral_q) && $stable(error_prev2_q),
    "controller state changed without an item")
  `PIDTM_ASSERT_NEXT(a_history_shift, step_i, error_prev2_q == $past(error_prev_q),
    "error history did not shift with the item")

endmodule

>>> design/pid_controller_three_mode_core.sv
// top level of the three-mode pid controller: config registers, pipeline and handshakes
//
//  channel   direction  handshake                  payload
//  in        input      in_valid_i / in_ready_o    measured_i
//  out       output     out_valid_o / out_ready_i  drive_o, drive_saturated_o
//  cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one item per cycle sustained while the output does not stall; an item passes the input,
// front, product and result registers before its result shows; the rate is set by the
// loops on the error history and integral in the front stage and on the drive accumulator in the sum stage
// stages: input register, front stage, three multipliers, sum and result register
// reset empties the pipeline, zeroes the state and loads the register defaults
// a stall at the output backs up stage by stage; empty stages still take items
`include "pid_controller_three_mode_core_assert.svh"

module pid_controller_three_mode_core import pidtm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  data_t                measured_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output data_t                drive_o,
  output logic                 drive_saturated_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  data_t                cfg_data_i
);

  data_t     gain_p_q, gain_i_q, gain_d_q, setpoint_q;
  data_t     integral_max_q, integral_min_q;
  law_mode_e law_mode_q;

  logic  s1_v_q, s2_v_q, s3_v_q, out_valid_q;
  data_t measured_q;
  opnd_t opnd, s2_q;
  logic  s3_ovf_q, s3_incr_q;
  data_t drive_accum_q;
  logic  drive_sat_q;

  logic  out_en, s3_en, s2_en, s1_en;
  logic  s1_move, s2_move, s3_move;

  data_t prod_p, prod_i, prod_d;
  logic  ovf_p, ovf_i, ovf_d;
  acc_t  sum_w;
  sat_t  drive_s;

  // a stage loads when it is empty or its item moves on
  assign out_en  = ~out_valid_q | out_ready_i;
  assign s3_en   = ~s3_v_q | out_en;
  assign s2_en   = ~s2_v_q | s3_en;
  assign s1_en   = ~s1_v_q | s2_en;
  assign s1_move = s1_v_q & s2_en;
  assign s2_move = s2_v_q & s3_en;
  assign s3_move = s3_v_q & out_en;

  assign in_ready_o  = s1_en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q       <= '0;
      gain_i_q       <= '0;
      gain_d_q       <= '0;
      setpoint_q     <= '0;
      law_mode_q     <= MODE_POS;
      integral_max_q <= DATA_MAX;
      integral_min_q <= DATA_MIN;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_GAIN_P:       gain_p_q       <= cfg_data_i;
        REG_GAIN_I:       gain_i_q       <= cfg_data_i;
        REG_GAIN_D:       gain_d_q       <= cfg_data_i;
        REG_SETPOINT:     setpoint_q     <= cfg_data_i;
        REG_LAW_MODE:     law_mode_q     <= law_mode_e'(cfg_data_i[1:0]);
        REG_INTEGRAL_MAX: integral_max_q <= cfg_data_i;
        REG_INTEGRAL_MIN: integral_min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_en) begin
        s3_v_q <= s2_v_q;
      end
      if (out_en) begin
        out_valid_q <= s3_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_en) begin
      measured_q <= measured_i;
    end
    if (s1_move) begin
      s2_q <= opnd;
    end
    if (s2_move) begin
      s3_ovf_q  <= s2_q.ovf;
      s3_incr_q <= s2_q.incr;
    end
    if (s3_move) begin
      drive_sat_q <= drive_s.ovf | s3_ovf_q | ovf_p | ovf_i | ovf_d;
    end
  end

  pidtm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (s1_move),
    .measured_i     (measured_q),
    .setpoint_i     (setpoint_q),
    .law_mode_i     (law_mode_q),
    .integral_max_i (integral_max_q),
    .integral_min_i (integral_min_q),
    .opnd_o         (opnd)
  );

  pidtm_mulq u_mul_p (
    .clk_i  (clk_i),
    .en_i   (s2_move),
    .gain_i (gain_p_q),
    .x_i    (s2_q.x_p),
    .prod_o (prod_p),
    .ovf_o  (ovf_p)
  );

  pidtm_mulq u_mul_i (
    .clk_i  (clk_i),
    .en_i   (s2_move),
    .gain_i (gain_i_q),
    .x_i    (s2_q.x_i),
    .prod_o (prod_i),
    .ovf_o  (ovf_i)
  );

  pidtm_mulq u_mul_d (
    .clk_i  (clk_i),
    .en_i   (s2_move),
    .gain_i (gain_d_q),
    .x_i    (s2_q.x_d),
    .prod_o (prod_d),
    .ovf_o  (ovf_d)
  );

  // incremental law adds onto the last drive of any mode
  always_comb begin
    sum_w = to_acc(prod_p) + to_acc(prod_i) + to_acc(prod_d)
          + (s3_incr_q ? to_acc(drive_accum_q) : '0);
    drive_s = sat_acc(sum_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_accum_q <= '0;
    end else if (s3_move) begin
      drive_accum_q <= drive_s.val;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_o           = drive_accum_q;
  assign drive_saturated_o = drive_sat_q;

  `PIDTM_ASSERT_NEXT(a_s3_held, s3_v_q && out_valid_q && !out_ready_i, s3_v_q,
    "product stage lost an item during an output stall")
  `PIDTM_ASSERT_NEXT(a_s2_to_s3, s2_v_q && s3_en, s3_v_q,
    "item did not reach the product stage")
  `PIDTM_ASSERT_NOW(a_full_backpressure,
    s1_v_q && s2_v_q && s3_v_q && out_valid_q && !out_ready_i, !in_ready_o,
    "input taken while the whole pipeline is stalled")

endmodule

>>> tb/pid_controller_three_mode_core_test.sv
// testbench of the three-mode pid controller: directed table, random phases, predictor
`timescale 1ns / 1ps

module pid_controller_three_mode_core_test;
  import pidtm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 16;
  localparam int ITEMS_PER_PHASE = 70;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    data_t drive;
    logic  sat;
  } drive_res_t;

  typedef struct {
    bit         known;
    drive_res_t res;
  } given_t;

  typedef enum {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  index;
    data_t                 value;
    bit                    known;
    data_t                 exp_drive;
    logic                  exp_sat;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  data_t                measured_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  data_t                drive_o;
  logic                 drive_saturated_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  data_t                cfg_data_i = '0;

  pid_controller_three_mode_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .measured_i        (measured_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .drive_o           (drive_o),
    .drive_saturated_o (drive_saturated_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // controller registers and state as the predictor sees them
  data_t      kp_reg = '0, ki_reg = '0, kd_reg = '0, target_reg = '0;
  logic [1:0] law_reg = MODE_POS;
  data_t      integ_hi_reg = DATA_MAX, integ_lo_reg = DATA_MIN;
  data_t      integ_acc = '0, err_prev1 = '0, err_before = '0, drive_last = '0;
  bit         drive_ovf;

  drive_res_t drive_q[$];
  given_t     given_q[$];
  row_t       directed_rows[$];
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         error_count = 0;
  int         result_count = 0;
  int         cycle_count = 0;

  function automatic longint clip32(longint x, bit flags);
    if (x > longint'(DATA_MAX)) begin
      if (flags) drive_ovf = 1'b1;
      return longint'(DATA_MAX);
    end
    if (x < longint'(DATA_MIN)) begin
      if (flags) drive_ovf = 1'b1;
      return longint'(DATA_MIN);
    end
    return x;
  endfunction

  // floor of the q16.16 product, saturated
  function automatic longint mul_q(longint a, longint b);
    return clip32((a * b) >>> FRAC_BITS, 1'b1);
  endfunction

  function automatic drive_res_t predict_drive(data_t meas);
    longint e, s, sum, drv, hi, lo, prev, prev2;
    drive_res_t r;
    drive_ovf = 1'b0;
    prev = longint'(err_prev1);
    prev2 = longint'(err_before);
    e = clip32(longint'(target_reg) - longint'(meas), 1'b1);
    if (law_reg == MODE_INCR) begin
      if (e < longint'(BAND_FINE) && e > -longint'(BAND_FINE)) e = 0;
      sum = mul_q(kp_reg, clip32(e - prev, 1'b1))
          + mul_q(ki_reg, e)
          + mul_q(kd_reg, clip32(e - 2 * prev + prev2, 1'b1));
      drv = clip32(longint'(drive_last) + sum, 1'b1);
    end else begin
      if (law_reg == MODE_BAND) begin
        hi = longint'(integ_hi_reg);
        lo = longint'(integ_lo_reg);
        if (e >= -longint'(BAND_WIDE) && e <= longint'(BAND_WIDE)) begin
          e = 0;
          integ_acc = '0;
        end
        if (e > -longint'(WINDOW) && e < longint'(WINDOW)) begin
          s = longint'(integ_acc) + e;
          // upper bound is tested first, so when the limits cross a sum above it takes it, any other the lower
          if (s > hi) s = hi;
          else if (s < lo) s = lo;
          integ_acc = data_t'(clip32(s, 1'b0));
        end
      end else begin
        integ_acc = data_t'(clip32(longint'(integ_acc) + e, 1'b0));
      end
      sum = mul_q(kp_reg, e) + mul_q(ki_reg, integ_acc) + mul_q(kd_reg, clip32(e - prev, 1'b1));
      drv = clip32(sum, 1'b1);
    end
    drive_last = data_t'(drv);
    err_before = err_prev1;
    err_prev1 = data_t'(e);
    r.drive = data_t'(drv);
    r.sat = drive_ovf;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic data_t fixed_of(int n);
    return data_t'(n <<< FRAC_BITS);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, data_t v);
    directed_rows.push_back('{ROW_CFG, idx, v, 1'b0, '0, 1'b0});
  endfunction

  function automatic void add_item(data_t m);
    directed_rows.push_back('{ROW_ITEM, '0, m, 1'b0, '0, 1'b0});
  endfunction

  function automatic void add_known(data_t m, data_t d, logic s);
    directed_rows.push_back('{ROW_ITEM, '0, m, 1'b1, d, s});
  endfunction

  function automatic data_t pick_value(int unsigned span);
    case ($urandom_range(0, 7))
      0: return DATA_MAX;
      1: return DATA_MIN;
      2: return data_t'($urandom);
      default: return data_t'(longint'($urandom_range(0, 2 * span)) - longint'(span));
    endcase
  endfunction

  // errors near the band and window edges, mostly errors within +-300, some raw and extreme values
  function automatic data_t pick_measured();
    longint e, sign, jitter;
    sign = $urandom_range(0, 1) ? 1 : -1;
    jitter = longint'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 9))
      0: return data_t'($urandom);
      1: return $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
      2: e = sign * longint'(BAND_WIDE) + jitter;
      3: e = sign * longint'(WINDOW) + jitter;
      4: e = sign * longint'(BAND_FINE) + jitter;
      default: e = longint'($urandom_range(0, 600 << FRAC_BITS)) - (300 << FRAC_BITS);
    endcase
    return data_t'(longint'(target_reg) - e);
  endfunction

  task automatic send_item(input data_t m, input bit known, input drive_res_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    given_q.push_back('{known, res});
    in_valid_i <= 1'b1;
    measured_i <= m;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input data_t v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (drive_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void build_directed();
    // reset state, error overflow on the positive side, difference overflow
    add_known('0, '0, 1'b0);
    add_known(DATA_MIN, '0, 1'b1);
    add_known(DATA_MAX, '0, 1'b1);
    add_known('0, '0, 1'b0);
    add_cfg(REG_GAIN_P, fixed_of(1));
    add_cfg(REG_UNUSED, 32'h5EED_F00D);
    add_known(fixed_of(-1), fixed_of(1), 1'b0);
    // extreme gains: large errors and differences saturate the products
    add_cfg(REG_GAIN_P, DATA_MAX);
    add_cfg(REG_GAIN_I, DATA_MIN);
    add_cfg(REG_GAIN_D, DATA_MIN);
    add_item(DATA_MIN);
    add_item(DATA_MAX);
    add_item(fixed_of(3));
    add_cfg(REG_SETPOINT, DATA_MAX);
    add_item(DATA_MIN);
    add_item(32'sh1);
    add_cfg(REG_SETPOINT, DATA_MIN);
    add_item(DATA_MAX);
    // dead band, integral window and clamps
    add_cfg(REG_GAIN_P, fixed_of(1));
    add_cfg(REG_GAIN_I, 32'sh0000_8000);
    add_cfg(REG_GAIN_D, 32'sh0000_4000);
    add_cfg(REG_SETPOINT, '0);
    add_cfg(REG_LAW_MODE, data_t'(MODE_BAND));
    add_cfg(REG_INTEGRAL_MAX, fixed_of(300));
    add_cfg(REG_INTEGRAL_MIN, fixed_of(-60));
    add_item(fixed_of(-50));
    add_item(fixed_of(50));
    add_item(fixed_of(-51));
    add_item(fixed_of(-199));
    add_item(fixed_of(-199));
    add_item(fixed_of(-200));
    add_item(fixed_of(199));
    add_item(fixed_of(199));
    // crossed limits
    add_cfg(REG_INTEGRAL_MAX, fixed_of(-10));
    add_cfg(REG_INTEGRAL_MIN, fixed_of(10));
    add_item(fixed_of(-100));
    // incremental law, fine band edges, continuing from the last drive
    add_cfg(REG_LAW_MODE, data_t'(MODE_INCR));
    add_item(NEG_BAND_FINE);
    add_item(BAND_FINE - 1);
    add_item(fixed_of(-5));
    // unused mode code falls back to positional
    add_cfg(REG_LAW_MODE, data_t'(MODE_UNUSED));
    add_item(fixed_of(7));
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pid_controller_three_mode_core_test failed");
      $finish;
    end
  end

  // register writes, accepted items and results
  always @(posedge clk_i) begin
    drive_res_t want;
    given_t given;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_GAIN_P:       kp_reg = cfg_data_i;
          REG_GAIN_I:       ki_reg = cfg_data_i;
          REG_GAIN_D:       kd_reg = cfg_data_i;
          REG_SETPOINT:     target_reg = cfg_data_i;
          REG_LAW_MODE:     law_reg = cfg_data_i[1:0];
          REG_INTEGRAL_MAX: integ_hi_reg = cfg_data_i;
          REG_INTEGRAL_MIN: integ_lo_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        want = predict_drive(measured_i);
        if (given_q.size() != 0) begin
          given = given_q.pop_front();
          if (given.known) want = given.res;
        end
        drive_q.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        if (drive_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no item pending", drive_o));
        end else begin
          want = drive_q.pop_front();
          if (drive_o !== want.drive)
            report_mismatch($sformatf("result %0d drive %h, expected %h",
                                      result_count, drive_o, want.drive));
          if (drive_saturated_o !== want.sat)
            report_mismatch($sformatf("result %0d saturated %b, expected %b",
                                      result_count, drive_saturated_o, want.sat));
        end
        result_count++;
      end
    end
  end

  initial begin
    row_t row;
    build_directed();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_CFG) begin
        in_valid_i <= 1'b0;
        wait_drained();
        write_reg(row.index, row.value);
      end else begin
        send_item(row.value, row.known, '{row.exp_drive, row.exp_sat});
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      case (ph / 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      write_reg(REG_GAIN_P, pick_value(4 << FRAC_BITS));
      write_reg(REG_GAIN_I, pick_value(4 << FRAC_BITS));
      write_reg(REG_GAIN_D, pick_value(4 << FRAC_BITS));
      write_reg(REG_SETPOINT, pick_value(1000 << FRAC_BITS));
      write_reg(REG_INTEGRAL_MAX, pick_value(400 << FRAC_BITS));
      write_reg(REG_INTEGRAL_MIN, pick_value(400 << FRAC_BITS));
      // all four mode codes, each under every idling pattern
      write_reg(REG_LAW_MODE, data_t'(ph % 4));
      repeat (ITEMS_PER_PHASE) send_item(pick_measured(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    stall_pct = 0;
    wait_drained();
    repeat (12) @(posedge clk_i);
    if (error_count == 0) begin
      $display("pid_controller_three_mode_core_test passed");
    end else begin
      $display("pid_controller_three_mode_core_test failed");
    end
    $finish;
  end

endmodule
